/* hw/rtl/stt_pkg.sv */
// ----------------------------------------------------------------------------
// stt_pkg: shared types for the software timer table
// Operation and result codes, controller states and the command/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package stt_pkg;

    typedef enum logic [1:0] {
        OP_REGISTER = 2'd0,
        OP_DELETE   = 2'd1,
        OP_TICK     = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        KIND_REGISTER = 2'd0,
        KIND_FIRED    = 2'd1,
        KIND_TICK     = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REG_SCAN,
        ST_DELETE,
        ST_TICK_PRIME,
        ST_TICK_RUN,
        ST_TICK_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic idx_clr;
        logic idx_inc;
        logic reg_write;
        logic reg_full;
        logic del;
        logic eval;
        logic tick_done;
    } t_dp_cmd;

    typedef struct packed {
        logic free_hit;
        logic idx_last;
        logic eval_last;
    } t_dp_stat;

endpackage

/* hw/rtl/stt_ctrl.sv */
// ----------------------------------------------------------------------------
// stt_ctrl: sequencer for the software timer table
// Decodes an accepted command and steps the datapath through the slot scan
// for register and tick, or the single-cycle slot release for delete.
// ----------------------------------------------------------------------------
module stt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [1:0]        i_operation,
    input  stt_pkg::t_dp_stat i_stat,
    output stt_pkg::t_dp_cmd  o_cmd,
    output logic              busy
);
    import stt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    case (i_operation)
                        OP_REGISTER: n_state = ST_REG_SCAN;
                        OP_DELETE:   n_state = ST_DELETE;
                        OP_TICK:     n_state = ST_TICK_PRIME;
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_REG_SCAN: begin
                if (i_stat.free_hit) begin
                    o_cmd.reg_write = 1'b1;
                    n_state         = ST_IDLE;
                end else if (i_stat.idx_last) begin
                    o_cmd.reg_full = 1'b1;
                    n_state        = ST_IDLE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            ST_DELETE: begin
                o_cmd.del = 1'b1;
                n_state   = ST_IDLE;
            end
            ST_TICK_PRIME: begin
                // first slot read is in flight; advance the read pointer
                o_cmd.idx_inc = 1'b1;
                n_state       = ST_TICK_RUN;
            end
            ST_TICK_RUN: begin
                o_cmd.eval    = 1'b1;
                o_cmd.idx_inc = 1'b1;
                if (i_stat.eval_last) begin
                    n_state = ST_TICK_DONE;
                end
            end
            ST_TICK_DONE: begin
                o_cmd.tick_done = 1'b1;
                n_state         = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy = (r_state != ST_IDLE);

endmodule

/* hw/rtl/stt_datapath.sv */
// ----------------------------------------------------------------------------
// stt_datapath: slot storage and result registers
// In-use flags in flip-flops, slot fields in memories with a registered read
// port, the slot pointer, and the countdown/fire logic of one slot per cycle.
// ----------------------------------------------------------------------------
module stt_datapath #(
    parameter int SLOTS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stt_pkg::t_dp_cmd  i_cmd,
    input  logic [15:0]       i_start_ticks,
    input  logic [15:0]       i_reload_period,
    input  logic [7:0]        i_callback,
    input  logic [31:0]       i_user_tag,
    input  logic [3:0]        i_slot_id,
    output stt_pkg::t_dp_stat o_stat,
    output logic              o_valid,
    output logic [1:0]        o_kind,
    output logic [3:0]        o_slot,
    output logic [7:0]        o_fired_callback,
    output logic [31:0]       o_fired_tag,
    output logic              o_last
);
    import stt_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    logic [SLOTS-1:0] r_in_use;

    logic [15:0] mem_rem [SLOTS];
    logic [15:0] mem_rel [SLOTS];
    logic [7:0]  mem_cb  [SLOTS];
    logic [31:0] mem_tag [SLOTS];

    logic [15:0] r_rd_rem;
    logic [15:0] r_rd_rel;
    logic [7:0]  r_rd_cb;
    logic [31:0] r_rd_tag;

    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_eval_idx;

    logic [15:0] r_start;
    logic [15:0] r_period;
    logic [7:0]  r_cb;
    logic [31:0] r_tag;
    logic [3:0]  r_del_id;

    logic        r_out_vld;
    logic [1:0]  r_out_kind;
    logic [3:0]  r_out_slot;
    logic [7:0]  r_out_cb;
    logic [31:0] r_out_tag;
    logic        r_out_last;

    logic        eval_act;
    logic [15:0] dec_rem;
    logic        fire;
    logic        del_ok;

    assign eval_act = i_cmd.eval && r_in_use[r_eval_idx];
    assign dec_rem  = (r_rd_rem != 16'd0) ? (r_rd_rem - 16'd1) : 16'd0;
    assign fire     = eval_act && (dec_rem == 16'd0) && (r_rd_cb != 8'd0);
    assign del_ok   = (32'(r_del_id) < SLOTS);

    assign o_stat.free_hit  = !r_in_use[r_idx];
    assign o_stat.idx_last  = (r_idx == LAST_IDX);
    assign o_stat.eval_last = (r_eval_idx == LAST_IDX);

    // capture the command beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_start  <= i_start_ticks;
            r_period <= i_reload_period;
            r_cb     <= i_callback;
            r_tag    <= i_user_tag;
            r_del_id <= i_slot_id;
        end
    end

    // slot pointer; hold at the last slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc && (r_idx != LAST_IDX)) begin
            r_idx <= r_idx + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_eval_idx <= r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= '0;
        end else if (i_cmd.reg_write) begin
            r_in_use[r_idx] <= 1'b1;
        end else if (i_cmd.del && del_ok) begin
            r_in_use[IW'(r_del_id)] <= 1'b0;
        end else if (fire && (r_rd_rel == 16'd0)) begin
            r_in_use[r_eval_idx] <= 1'b0;
        end
    end

    // slot memories: one write port, registered read at the pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.reg_write) begin
            mem_rem[r_idx] <= r_start;
            mem_rel[r_idx] <= r_period;
            mem_cb[r_idx]  <= r_cb;
            mem_tag[r_idx] <= r_tag;
        end else if (eval_act) begin
            mem_rem[r_eval_idx] <= fire ? r_rd_rel : dec_rem;
        end
        r_rd_rem <= mem_rem[r_idx];
        r_rd_rel <= mem_rel[r_idx];
        r_rd_cb  <= mem_cb[r_idx];
        r_rd_tag <= mem_tag[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= i_cmd.reg_write | i_cmd.reg_full | fire | i_cmd.tick_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_kind <= KIND_FIRED;
            r_out_slot <= 4'(r_eval_idx);
            r_out_cb   <= r_rd_cb;
            r_out_tag  <= r_rd_tag;
            r_out_last <= 1'b0;
        end else begin
            r_out_kind <= i_cmd.tick_done ? KIND_TICK : KIND_REGISTER;
            r_out_slot <= i_cmd.reg_full ? 4'(SLOTS) :
                          (i_cmd.tick_done ? 4'd0 : 4'(r_idx));
            r_out_cb   <= 8'd0;
            r_out_tag  <= 32'd0;
            r_out_last <= 1'b1;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_kind           = r_out_kind;
    assign o_slot           = r_out_slot;
    assign o_fired_callback = r_out_cb;
    assign o_fired_tag      = r_out_tag;
    assign o_last           = r_out_last;

endmodule

/* hw/rtl/software_timer_table_unit.sv */
// ----------------------------------------------------------------------------
// software_timer_table_unit: multi-channel software timer table
// Register, delete and tick commands over a table of SLOTS timer slots.
//
// Channel   Direction  Handshake            Payload
// command   in         start & !busy        i_operation, i_start_ticks,
//                                           i_reload_period, i_callback,
//                                           i_user_tag, i_slot_id
// result    out        o_valid (one cycle)  o_kind, o_slot, o_fired_callback,
//                                           o_fired_tag, o_last
//
// Register searches for a free slot, checking one in-use flag per cycle.
// Tick evaluates one slot per cycle through the registered read of the slot
// memories, after a read-priming step and before the tick-done beat. Each
// result shows in the cycle after it is produced; the final beat of a
// command arrives as busy drops.
// Reset clears the in-use flags at once; slot memories need no clearing.
// The receiver cannot stall: every beat is taken in its cycle.
// ----------------------------------------------------------------------------
module software_timer_table_unit #(
    parameter int SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_start_ticks,
    input  logic [15:0] i_reload_period,
    input  logic [7:0]  i_callback,
    input  logic [31:0] i_user_tag,
    input  logic [3:0]  i_slot_id,
    output logic        o_valid,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_slot,
    output logic [7:0]  o_fired_callback,
    output logic [31:0] o_fired_tag,
    output logic        o_last
);
    import stt_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    stt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_operation (i_operation),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .busy        (busy)
    );

    stt_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_start_ticks    (i_start_ticks),
        .i_reload_period  (i_reload_period),
        .i_callback       (i_callback),
        .i_user_tag       (i_user_tag),
        .i_slot_id        (i_slot_id),
        .o_stat           (stat),
        .o_valid          (o_valid),
        .o_kind           (o_kind),
        .o_slot           (o_slot),
        .o_fired_callback (o_fired_callback),
        .o_fired_tag      (o_fired_tag),
        .o_last           (o_last)
    );

    // the closing beat of a command lands as the sequencer returns to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> !busy)
        else $error("last beat while still busy");

    // a fired beat is never the closing beat and always carries a handler
    a_fired_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == KIND_FIRED)) |-> (!o_last && (o_fired_callback != 8'd0)))
        else $error("malformed fired beat");

    // an accepted tick keeps the block busy
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation == OP_TICK)) |=> busy)
        else $error("tick accepted but block not busy");

    // no beat appears while idle unless a command just finished
    a_no_stray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !busy) |-> o_last)
        else $error("stray beat while idle");

endmodule
